// ===== rtl/pid_timed_integral_reset_macros.svh =====
// Assertion macros for the PID regulator block.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef PID_TIMED_INTEGRAL_RESET_MACROS_SVH
`define PID_TIMED_INTEGRAL_RESET_MACROS_SVH

// same-cycle implication
`define PTIR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTIR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ptir_pkg.sv =====
// Package for the PID regulator: word types, widths, register codes, reset values.
// No dependencies; used by every module of the block.
package ptir_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int TIME_BITS     = 32;
    localparam int GAIN_BITS     = 32;
    localparam int LIMIT_BITS    = 8;
    localparam int DRIVE_BITS    = 8;
    localparam int DRIVE_MAX     = 127;
    localparam int FRAC_BITS     = 24;
    localparam int SUM_BITS_DEF  = 48;

    localparam int ERR_BITS      = SAMPLE_BITS + 1;
    localparam int DEMAG_BITS    = SAMPLE_BITS + 1;
    localparam int MUL_BITS      = 32;
    localparam int PROD_BITS     = 2 * MUL_BITS;
    localparam int INCM_BITS     = SAMPLE_BITS + TIME_BITS;
    localparam int PMAG_BITS     = SAMPLE_BITS + GAIN_BITS;
    localparam int DIV_NUM_BITS  = DEMAG_BITS + GAIN_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_NUM_BITS + 1);

    localparam int KI_SHIFT      = 16;
    localparam int HI_KEEP       = 34;
    localparam int IMAG_BITS     = HI_KEEP + KI_SHIFT + 1;
    localparam int I_CAP_EXP     = 50;
    localparam int TOT_BITS      = IMAG_BITS + 2;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TARGET = 3'd0,
        CFG_KP     = 3'd1,
        CFG_KI     = 3'd2,
        CFG_KD     = 3'd3,
        CFG_PLIM   = 3'd4,
        CFG_DLIM   = 3'd5
    } t_cfg_idx;

    localparam logic [SAMPLE_BITS-1:0] TARGET_RST = SAMPLE_BITS'(2048);
    localparam logic [GAIN_BITS-1:0]   KP_RST     = 32'd251658;
    localparam logic [GAIN_BITS-1:0]   KI_RST     = 32'd54976;
    localparam logic [GAIN_BITS-1:0]   KD_RST     = 32'd2013265920;
    localparam logic [LIMIT_BITS-1:0]  PLIM_RST   = 8'd20;
    localparam logic [GAIN_BITS-1:0]   DLIM_RST   = 32'd3355443;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] measurement;
        logic [TIME_BITS-1:0]   timestamp_us;
    } t_in_word;

    typedef struct packed {
        logic signed [DRIVE_BITS-1:0] drive;
        logic                         sum_cleared;
    } t_out_word;

    typedef struct packed {
        logic                    start;
        logic [DIV_NUM_BITS-1:0] dividend;
        logic [TIME_BITS-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic [DIV_NUM_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== rtl/pid_timed_integral_reset.sv =====
// PID regulator. One word is taken, then the block stalls its input, taking no new word until
// the result is in the output register, while a sequencer runs the error products, the
// saturating sum update, a 45-step restoring divide for the derivative and the two integral
// partial products through one shared 32x32 multiplier; the divide is the longest of these
// steps. The result sits in an output register until taken; a result still waiting there
// holds the sequencer in its last step. Configuration is accepted only while idle.
// Depends on ptir_pkg, ptir_mul, ptir_div and pid_timed_integral_reset_macros.svh.
`include "pid_timed_integral_reset_macros.svh"

module pid_timed_integral_reset #(
    parameter int SUM_BITS = ptir_pkg::SUM_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  ptir_pkg::t_in_word                    i_in_word,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output ptir_pkg::t_out_word                   o_out_word,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ptir_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [ptir_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int SB   = ptir_pkg::SAMPLE_BITS;
    localparam int EB   = ptir_pkg::ERR_BITS;
    localparam int TB   = ptir_pkg::TIME_BITS;
    localparam int GB   = ptir_pkg::GAIN_BITS;
    localparam int PB   = ptir_pkg::PROD_BITS;
    localparam int MB   = ptir_pkg::MUL_BITS;
    localparam int IMB  = ptir_pkg::INCM_BITS;
    localparam int SUMX = ((SUM_BITS > IMB + 1) ? SUM_BITS : IMB + 1) + 1;
    localparam int SW1  = PB + 1;
    localparam int TOT  = ptir_pkg::TOT_BITS;
    localparam int IB   = ptir_pkg::IMAG_BITS;
    localparam int FB   = ptir_pkg::FRAC_BITS;
    localparam int QB   = TOT - FB;
    localparam int DB   = ptir_pkg::DRIVE_BITS;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'h0001,
        ST_M1    = 13'h0002,
        ST_M2    = 13'h0004,
        ST_M3    = 13'h0008,
        ST_DIV   = 13'h0010,
        ST_DWAIT = 13'h0020,
        ST_MAG   = 13'h0040,
        ST_I1    = 13'h0080,
        ST_I2    = 13'h0100,
        ST_I3    = 13'h0200,
        ST_SUM1  = 13'h0400,
        ST_SUM2  = 13'h0800,
        ST_OUT   = 13'h1000
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_out_valid, n_out_valid;
    ptir_pkg::t_out_word             r_out_word, n_out_word;
    logic [TB-1:0]                   r_prev_time, n_prev_time;
    logic signed [EB-1:0]            r_prev_err, n_prev_err;
    logic signed [SUM_BITS-1:0]      r_sum, n_sum;

    logic [SB-1:0]                   r_target, n_target;
    logic [GB-1:0]                   r_kp, n_kp;
    logic [GB-1:0]                   r_ki, n_ki;
    logic [GB-1:0]                   r_kd, n_kd;
    logic [ptir_pkg::LIMIT_BITS-1:0] r_plim, n_plim;
    logic [GB-1:0]                   r_dlim, n_dlim;

    logic [SB-1:0]                       r_emag, n_emag;
    logic                                r_e_neg, n_e_neg;
    logic [ptir_pkg::DEMAG_BITS-1:0]     r_demag, n_demag;
    logic                                r_de_neg, n_de_neg;
    logic [TB-1:0]                       r_dt, n_dt;
    logic [ptir_pkg::PMAG_BITS-1:0]      r_pmag, n_pmag;
    logic [ptir_pkg::DIV_NUM_BITS-1:0]   r_dmag, n_dmag;
    logic                                r_clr, n_clr;
    logic [PB-1:0]                       r_smag, n_smag;
    logic                                r_sum_neg, n_sum_neg;
    logic [ptir_pkg::HI_KEEP-1:0]        r_hi, n_hi;
    logic                                r_hi_big, n_hi_big;
    logic [IB-1:0]                       r_imag, n_imag;
    logic signed [TOT-1:0]               r_tot, n_tot;

    logic                            in_accept;
    logic signed [EB-1:0]            cur_err;
    logic signed [EB:0]              cur_derr;
    logic [EB-1:0]                   eabs;
    logic [EB:0]                     deabs;
    logic [MB-1:0]                   mul_a, mul_b;
    logic [PB-1:0]                   prod;
    logic signed [SUMX-1:0]          inc_x, sum_add, smax_x, smin_x;
    logic [SW1-1:0]                  sum_w, smag_w;
    logic [ptir_pkg::DIV_NUM_BITS-1:0] dmag;
    logic                            clr_now;
    logic [IB-1:0]                   ipart, icap;
    logic [TOT-1:0]                  p_x, d_x, i_x, tabs;
    logic signed [TOT-1:0]           p_s, d_s, i_s;
    logic [QB-1:0]                   qm;
    logic [DB-1:0]                   q8;
    ptir_pkg::t_div_req              div_req;
    ptir_pkg::t_div_rsp              div_rsp;

    ptir_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    ptir_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // error terms from the incoming word
    assign cur_err  = EB'(i_in_word.measurement) - EB'(r_target);
    assign cur_derr = {cur_err[EB-1], cur_err} - {r_prev_err[EB-1], r_prev_err};
    assign eabs     = cur_err[EB-1] ? -cur_err : cur_err;
    assign deabs    = cur_derr[EB] ? -cur_derr : cur_derr;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_M1: begin
                mul_a = MB'(r_emag);
                mul_b = r_dt;
            end
            ST_M2: begin
                mul_a = MB'(r_emag);
                mul_b = r_kp;
            end
            ST_M3: begin
                mul_a = MB'(r_demag);
                mul_b = r_kd;
            end
            ST_I1: begin
                mul_a = r_smag[PB-1:MB];
                mul_b = r_ki;
            end
            ST_I2: begin
                mul_a = r_smag[MB-1:0];
                mul_b = r_ki;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // saturating sum update
    assign smax_x  = SUMX'(signed'({1'b0, {(SUM_BITS-1){1'b1}}}));
    assign smin_x  = -smax_x - SUMX'(1);
    assign inc_x   = r_e_neg ? -SUMX'(prod[IMB-1:0]) : SUMX'(prod[IMB-1:0]);
    assign sum_add = SUMX'(r_sum) + inc_x;

    assign sum_w   = SW1'(r_sum);
    assign smag_w  = r_sum[SUM_BITS-1] ? -sum_w : sum_w;

    assign dmag    = (r_dt == '0) ? '0 : div_rsp.quotient;
    assign clr_now = (r_pmag > ptir_pkg::PMAG_BITS'({r_plim, {FB{1'b0}}})) ||
                     (!r_de_neg && (dmag > ptir_pkg::DIV_NUM_BITS'(r_dlim)));

    assign icap  = IB'(1) << ptir_pkg::I_CAP_EXP;
    assign ipart = IB'({r_hi, {ptir_pkg::KI_SHIFT{1'b0}}}) +
                   IB'(prod[PB-1:ptir_pkg::KI_SHIFT]);

    assign p_x = TOT'(r_pmag);
    assign d_x = TOT'(r_dmag);
    assign i_x = TOT'(r_imag);
    assign p_s = r_e_neg ? -p_x : p_x;
    assign d_s = r_de_neg ? -d_x : d_x;
    assign i_s = r_sum_neg ? -i_x : i_x;

    assign tabs = r_tot[TOT-1] ? -r_tot : r_tot;
    assign qm   = tabs[TOT-1:FB];
    assign q8   = (qm > QB'(ptir_pkg::DRIVE_MAX)) ? DB'(ptir_pkg::DRIVE_MAX) : DB'(qm);

    always_comb begin
        div_req.start    = (r_state == ST_DIV);
        div_req.dividend = prod[ptir_pkg::DIV_NUM_BITS-1:0];
        div_req.divisor  = r_dt;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        n_prev_time = r_prev_time;
        n_prev_err  = r_prev_err;
        n_sum       = r_sum;
        n_target    = r_target;
        n_kp        = r_kp;
        n_ki        = r_ki;
        n_kd        = r_kd;
        n_plim      = r_plim;
        n_dlim      = r_dlim;
        n_emag      = r_emag;
        n_e_neg     = r_e_neg;
        n_demag     = r_demag;
        n_de_neg    = r_de_neg;
        n_dt        = r_dt;
        n_pmag      = r_pmag;
        n_dmag      = r_dmag;
        n_clr       = r_clr;
        n_smag      = r_smag;
        n_sum_neg   = r_sum_neg;
        n_hi        = r_hi;
        n_hi_big    = r_hi_big;
        n_imag      = r_imag;
        n_tot       = r_tot;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid && o_cfg_ready) begin
            case (ptir_pkg::t_cfg_idx'(i_cfg_index))
                ptir_pkg::CFG_TARGET: n_target = i_cfg_data[SB-1:0];
                ptir_pkg::CFG_KP:     n_kp     = i_cfg_data[GB-1:0];
                ptir_pkg::CFG_KI:     n_ki     = i_cfg_data[GB-1:0];
                ptir_pkg::CFG_KD:     n_kd     = i_cfg_data[GB-1:0];
                ptir_pkg::CFG_PLIM:   n_plim   = i_cfg_data[ptir_pkg::LIMIT_BITS-1:0];
                ptir_pkg::CFG_DLIM:   n_dlim   = i_cfg_data[GB-1:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_emag      = eabs[SB-1:0];
                    n_e_neg     = cur_err[EB-1];
                    n_demag     = deabs[ptir_pkg::DEMAG_BITS-1:0];
                    n_de_neg    = cur_derr[EB];
                    n_dt        = i_in_word.timestamp_us - r_prev_time;
                    n_prev_time = i_in_word.timestamp_us;
                    n_prev_err  = cur_err;
                    n_state     = ST_M1;
                end
            end
            ST_M1: n_state = ST_M2;
            ST_M2: begin
                if (sum_add > smax_x) begin
                    n_sum = smax_x[SUM_BITS-1:0];
                end else if (sum_add < smin_x) begin
                    n_sum = smin_x[SUM_BITS-1:0];
                end else begin
                    n_sum = sum_add[SUM_BITS-1:0];
                end
                n_state = ST_M3;
            end
            ST_M3: begin
                n_pmag  = prod[ptir_pkg::PMAG_BITS-1:0];
                n_state = ST_DIV;
            end
            ST_DIV: n_state = ST_DWAIT;
            ST_DWAIT: begin
                if (div_rsp.done) begin
                    n_dmag  = dmag;
                    n_clr   = clr_now;
                    if (clr_now) begin
                        n_sum = '0;
                    end
                    n_state = ST_MAG;
                end
            end
            ST_MAG: begin
                n_smag    = smag_w[PB-1:0];
                n_sum_neg = r_sum[SUM_BITS-1];
                n_state   = ST_I1;
            end
            ST_I1: n_state = ST_I2;
            ST_I2: begin
                n_hi     = prod[ptir_pkg::HI_KEEP-1:0];
                n_hi_big = |prod[PB-1:ptir_pkg::HI_KEEP];
                n_state  = ST_I3;
            end
            ST_I3: begin
                if (r_hi_big || (ipart > icap)) begin
                    n_imag = icap;
                end else begin
                    n_imag = ipart;
                end
                n_state = ST_SUM1;
            end
            ST_SUM1: begin
                n_tot   = p_s + d_s;
                n_state = ST_SUM2;
            end
            ST_SUM2: begin
                n_tot   = r_tot + i_s;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_word.drive       = r_tot[TOT-1] ? q8 : -q8;
                    n_out_word.sum_cleared = r_clr;
                    n_out_valid            = 1'b1;
                    n_state                = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_prev_time <= '0;
            r_prev_err  <= '0;
            r_sum       <= '0;
            r_target    <= ptir_pkg::TARGET_RST;
            r_kp        <= ptir_pkg::KP_RST;
            r_ki        <= ptir_pkg::KI_RST;
            r_kd        <= ptir_pkg::KD_RST;
            r_plim      <= ptir_pkg::PLIM_RST;
            r_dlim      <= ptir_pkg::DLIM_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_prev_time <= n_prev_time;
            r_prev_err  <= n_prev_err;
            r_sum       <= n_sum;
            r_target    <= n_target;
            r_kp        <= n_kp;
            r_ki        <= n_ki;
            r_kd        <= n_kd;
            r_plim      <= n_plim;
            r_dlim      <= n_dlim;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_emag     <= n_emag;
        r_e_neg    <= n_e_neg;
        r_demag    <= n_demag;
        r_de_neg   <= n_de_neg;
        r_dt       <= n_dt;
        r_pmag     <= n_pmag;
        r_dmag     <= n_dmag;
        r_clr      <= n_clr;
        r_smag     <= n_smag;
        r_sum_neg  <= n_sum_neg;
        r_hi       <= n_hi;
        r_hi_big   <= n_hi_big;
        r_imag     <= n_imag;
        r_tot      <= n_tot;
    end

    `PTIR_ASSERT_NXT(a_busy_after_accept, in_accept, o_in_stall, "input not stalled after accept")
    `PTIR_ASSERT_IMP(a_div_done_in_wait, div_rsp.done, r_state == ST_DWAIT, "divide done out of turn")
    `PTIR_ASSERT_IMP(a_out_from_final, $rose(r_out_valid), $past(r_state) == ST_OUT, "stray output word")
    `PTIR_ASSERT_IMP(a_clear_zeroes_sum, (r_state == ST_MAG) && r_clr, r_sum == '0, "sum not cleared")

endmodule

// ===== rtl/ptir_mul.sv =====
// Shared 32x32 unsigned multiplier with registered product.
// Depends on ptir_pkg for widths.
module ptir_mul (
    input  logic                             i_clk,
    input  logic [ptir_pkg::MUL_BITS-1:0]    i_a,
    input  logic [ptir_pkg::MUL_BITS-1:0]    i_b,
    output logic [ptir_pkg::PROD_BITS-1:0]   o_prod
);

    logic [ptir_pkg::PROD_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= ptir_pkg::PROD_BITS'(i_a) * ptir_pkg::PROD_BITS'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/ptir_div.sv =====
// Restoring divider, one quotient bit per cycle, for the derivative term.
// Depends on ptir_pkg for widths and request/response types.
module ptir_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptir_pkg::t_div_req  i_req,
    output ptir_pkg::t_div_rsp  o_rsp
);

    localparam int N = ptir_pkg::DIV_NUM_BITS;
    localparam int D = ptir_pkg::TIME_BITS;

    logic                               r_busy, n_busy;
    logic                               r_done, n_done;
    logic [ptir_pkg::DIV_CNT_BITS-1:0]  r_cnt, n_cnt;
    logic [D-1:0]                       r_rem, n_rem;
    logic [N-1:0]                       r_quo, n_quo;
    logic [D-1:0]                       r_dsr, n_dsr;
    logic [D:0]                         rem_sh;
    logic [D+1:0]                       diff;
    logic                               ge;

    assign rem_sh = {r_rem, r_quo[N-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dsr};
    assign ge     = !diff[D+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = ptir_pkg::DIV_CNT_BITS'(N);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dsr  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[D-1:0] : rem_sh[D-1:0];
            n_quo = {r_quo[N-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == ptir_pkg::DIV_CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
